### rtl/core/php_pkg.sv
package php_pkg;

    localparam int COORD_W  = 20;
    localparam int POS_W    = 20;
    localparam int ROT_W    = 16;
    localparam int FOCAL_W  = 16;
    localparam int COEF_W   = 20;
    localparam int ROW_W    = 3 * ROT_W;
    localparam int CFG_W    = 60;
    localparam int CFG_IDX_W = 3;

    localparam int NORM_SHIFT_DEF = 10;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 4 * POS_W;
    localparam int M_TUSER_W = 2;

    localparam logic signed [63:0] POS_MAX = 64'sd524287;
    localparam logic signed [63:0] POS_MIN = -64'sd524288;

    localparam logic [ROW_W-1:0]    ROT_ROW_0_RST = 48'd16384;
    localparam logic [ROW_W-1:0]    ROT_ROW_1_RST = 48'd1073741824;
    localparam logic [ROW_W-1:0]    ROT_ROW_2_RST = 48'd70368744177664;
    localparam logic [FOCAL_W-1:0]  FOCAL_RST     = 16'd16000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW_0,
        REG_ROT_ROW_1,
        REG_ROT_ROW_2,
        REG_CAMERA_CENTER,
        REG_FOCAL_LENGTH,
        REG_PRINCIPAL_POINT,
        REG_DISTORTION_CENTER,
        REG_DISTORTION_COEFS
    } cfg_index_t;

endpackage

### rtl/core/pinhole_projection_with_distortion.sv
// Channel   Direction  Handshake            Payload
// s_        input      s_tvalid / s_tready  s_tdata: point_x, point_y, point_z
// m_        output     m_tvalid / m_tready  m_tdata: image_x/y, distorted_x/y;
//                                           m_tuser: behind_camera, saturated
// cfg_      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One point is accepted per cycle while the output is not stalled; each point
// passes through the whole pipeline, of which 7 stages are the restoring
// divider (3 quotient bits per stage).
// Reset is synchronous and active low; it clears the stage valid bits and
// loads the configuration registers with their default values.
// When the result is not taken, the whole pipeline holds and s_tready drops.
module pinhole_projection_with_distortion #(
    parameter int NORM_SHIFT = php_pkg::NORM_SHIFT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [php_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [php_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_x [19:0], point_y [39:20], point_z [59:40], zero [63:60]
    input  logic [php_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // image_x [19:0], image_y [39:20], distorted_x [59:40], distorted_y [79:60]
    output logic [php_pkg::M_TDATA_W-1:0]   m_tdata,
    // behind_camera [0], saturated [1]
    output logic [php_pkg::M_TUSER_W-1:0]   m_tuser
);
    import php_pkg::*;

    localparam int D_W     = COORD_W + 1;
    localparam int PROD_W  = ROT_W + D_W;
    localparam int T_W     = PROD_W + 2;
    localparam int N_W     = T_W + FOCAL_W + 1;
    localparam int REM_W   = N_W;
    localparam int DEN_W   = T_W;
    localparam int QBITS   = POS_W + 1;
    localparam int CMP_W   = DEN_W + QBITS;
    localparam int DIV_STEP = 3;
    localparam int DIV_STAGES = (QBITS + DIV_STEP - 1) / DIV_STEP;
    localparam int NST     = 5 + DIV_STAGES + 10;
    localparam int OFF_W   = POS_W + 1;
    localparam int SQ_W    = 2 * OFF_W;
    localparam int D2_W    = SQ_W + 8;
    localparam int SH_L    = (2 * NORM_SHIFT >= 8) ? 0 : 8 - 2 * NORM_SHIFT;
    localparam int SH_R    = (2 * NORM_SHIFT >= 8) ? 2 * NORM_SHIFT - 8 : 0;
    localparam int PW_W    = 41;
    localparam int F_W     = COEF_W + PW_W + 1;
    localparam int FACT_W  = PW_W + 1;
    localparam int DIS_W   = OFF_W + FACT_W;
    localparam int SIDE_N  = 9;
    localparam logic [PW_W-1:0] POW_CAP = PW_W'(1) << 40;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QBITS-1:0] q;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef struct packed {
        logic [DEN_W-1:0] den2;
        logic             behind;
    } div_ctl_t;

    typedef struct packed {
        logic                    behind;
        logic                    sat;
        logic signed [POS_W-1:0] img_x;
        logic signed [POS_W-1:0] img_y;
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
    } side_t;

    function automatic logic [POS_W:0] clip_pos(input logic signed [63:0] v);
        logic [POS_W:0] r;
        if (v > POS_MAX) begin
            r = {1'b1, POS_MAX[POS_W-1:0]};
        end else if (v < POS_MIN) begin
            r = {1'b1, POS_MIN[POS_W-1:0]};
        end else begin
            r = {1'b0, v[POS_W-1:0]};
        end
        return r;
    endfunction

    // Configuration registers.
    logic [ROW_W-1:0]   rot_reg [3];
    logic [CFG_W-1:0]   cc_reg;
    logic [FOCAL_W-1:0] focal_reg;
    logic [2*POS_W-1:0] pp_reg;
    logic [2*POS_W-1:0] dc_reg;
    logic [CFG_W-1:0]   coef_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0] <= ROT_ROW_0_RST;
            rot_reg[1] <= ROT_ROW_1_RST;
            rot_reg[2] <= ROT_ROW_2_RST;
            cc_reg     <= '0;
            focal_reg  <= FOCAL_RST;
            pp_reg     <= '0;
            dc_reg     <= '0;
            coef_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                REG_ROT_ROW_0:         rot_reg[0] <= cfg_wdata[ROW_W-1:0];
                REG_ROT_ROW_1:         rot_reg[1] <= cfg_wdata[ROW_W-1:0];
                REG_ROT_ROW_2:         rot_reg[2] <= cfg_wdata[ROW_W-1:0];
                REG_CAMERA_CENTER:     cc_reg     <= cfg_wdata;
                REG_FOCAL_LENGTH:      focal_reg  <= cfg_wdata[FOCAL_W-1:0];
                REG_PRINCIPAL_POINT:   pp_reg     <= cfg_wdata[2*POS_W-1:0];
                REG_DISTORTION_CENTER: dc_reg     <= cfg_wdata[2*POS_W-1:0];
                REG_DISTORTION_COEFS:  coef_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline control: every stage advances unless the output is blocked.
    logic           en;
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;

    assign en         = !valid_reg[NST-1] || m_tready;
    assign s_tready   = en;
    assign valid_next = {valid_reg[NST-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: offsets from the camera center.
    logic signed [D_W-1:0] d_next [3];
    logic signed [D_W-1:0] d_reg  [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_next[i] = D_W'($signed(s_tdata[COORD_W*i +: COORD_W]))
                      - D_W'($signed(cc_reg[COORD_W*i +: COORD_W]));
        end
    end

    // Stage 2: the nine rotation products.
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                prod_next[j][i] = $signed(rot_reg[i][ROT_W*j +: ROT_W]) * d_reg[i];
            end
        end
    end

    // Stage 3: camera-frame coordinates.
    logic signed [T_W-1:0] t_next [3];
    logic signed [T_W-1:0] t_reg  [3];
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            t_next[j] = T_W'(prod_reg[j][0]) + T_W'(prod_reg[j][1])
                      + T_W'(prod_reg[j][2]);
        end
    end

    // Stage 4: numerators scaled by the focal length.
    logic signed [N_W-1:0] n_next [2];
    logic signed [N_W-1:0] n_reg  [2];
    logic signed [T_W-1:0] tz_reg;
    logic                  behind_next;
    logic                  behind_reg;
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            n_next[i] = t_reg[i] * $signed({1'b0, focal_reg});
        end
        behind_next = (t_reg[2] <= 0);
    end

    // Stage 5: divider set-up. Rounding to nearest is (2|n| + z) / (2z).
    div_lane_t div_lane_next [DIV_STAGES+1][2];
    div_lane_t div_lane_reg  [DIV_STAGES+1][2];
    div_ctl_t  div_ctl_next  [DIV_STAGES+1];
    div_ctl_t  div_ctl_reg   [DIV_STAGES+1];

    always_comb begin
        logic [N_W-1:0]   mag;
        logic [DEN_W-1:0] den2;
        logic [REM_W-1:0] num;
        den2 = {tz_reg[DEN_W-2:0], 1'b0};
        for (int i = 0; i < 2; i++) begin
            mag = n_reg[i][N_W-1] ? N_W'(-n_reg[i]) : N_W'(n_reg[i]);
            num = {mag[REM_W-2:0], 1'b0} + REM_W'(tz_reg[DEN_W-2:0]);
            div_lane_next[0][i].rem = num;
            div_lane_next[0][i].q   = '0;
            div_lane_next[0][i].neg = n_reg[i][N_W-1];
            div_lane_next[0][i].ovf = (CMP_W'(num) >= (CMP_W'(den2) << QBITS));
        end
        div_ctl_next[0].den2   = den2;
        div_ctl_next[0].behind = behind_reg;
    end

    // Divider stages, quotient bits most significant first.
    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        always_comb begin
            logic [REM_W-1:0] rem;
            logic [QBITS-1:0] q;
            logic [CMP_W-1:0] sub;
            int               b;
            for (int i = 0; i < 2; i++) begin
                rem = div_lane_reg[k-1][i].rem;
                q   = div_lane_reg[k-1][i].q;
                for (int s = 0; s < DIV_STEP; s++) begin
                    b = QBITS - 1 - ((k - 1) * DIV_STEP + s);
                    if (b >= 0) begin
                        sub = CMP_W'(div_ctl_reg[k-1].den2) << b;
                        if (CMP_W'(rem) >= sub) begin
                            rem = rem - sub[REM_W-1:0];
                            q   = {q[QBITS-2:0], 1'b1};
                        end else begin
                            q   = {q[QBITS-2:0], 1'b0};
                        end
                    end
                end
                div_lane_next[k][i].rem = rem;
                div_lane_next[k][i].q   = q;
                div_lane_next[k][i].neg = div_lane_reg[k-1][i].neg;
                div_lane_next[k][i].ovf = div_lane_reg[k-1][i].ovf;
            end
            div_ctl_next[k] = div_ctl_reg[k-1];
        end
    end

    // Image stage: add the principal point, clip, take the distortion offset.
    side_t side_next [SIDE_N];
    side_t side_reg  [SIDE_N];

    always_comb begin
        logic [QBITS:0]          rmag;
        logic signed [QBITS+1:0] r;
        logic signed [QBITS+2:0] v;
        logic [POS_W:0]          c [2];
        for (int i = 0; i < 2; i++) begin
            rmag = div_lane_reg[DIV_STAGES][i].ovf ? (QBITS+1)'(1) << QBITS
                                                    : {1'b0, div_lane_reg[DIV_STAGES][i].q};
            r = div_lane_reg[DIV_STAGES][i].neg ? -$signed({1'b0, rmag})
                                                : $signed({1'b0, rmag});
            v = (QBITS+3)'($signed(pp_reg[POS_W*i +: POS_W])) + (QBITS+3)'(r);
            c[i] = clip_pos(64'(v));
        end
        side_next[0].behind = div_ctl_reg[DIV_STAGES].behind;
        side_next[0].sat    = c[0][POS_W] | c[1][POS_W];
        side_next[0].img_x  = $signed(c[0][POS_W-1:0]);
        side_next[0].img_y  = $signed(c[1][POS_W-1:0]);
        side_next[0].off_x  = OFF_W'($signed(c[0][POS_W-1:0]))
                            - OFF_W'($signed(dc_reg[POS_W-1:0]));
        side_next[0].off_y  = OFF_W'($signed(c[1][POS_W-1:0]))
                            - OFF_W'($signed(dc_reg[2*POS_W-1:POS_W]));
        for (int s = 1; s < SIDE_N; s++) begin
            side_next[s] = side_reg[s-1];
        end
    end

    // Squared radius.
    logic signed [SQ_W-1:0] sqx;
    logic signed [SQ_W-1:0] sqy;
    logic [SQ_W-1:0]        sq_next;
    logic [SQ_W-1:0]        sq_reg;
    assign sqx     = side_reg[0].off_x * side_reg[0].off_x;
    assign sqy     = side_reg[0].off_y * side_reg[0].off_y;
    assign sq_next = SQ_W'(sqx[SQ_W-2:0]) + SQ_W'(sqy[SQ_W-2:0]);

    // Normalized radius; d2 at or above 2^28 saturates both powers.
    logic [D2_W-1:0] d2w;
    logic            big_next, big_reg, big_p2_reg, big_a_reg;
    logic [27:0]     d2lo_next, d2lo_reg, d2lo_p2_reg;
    logic [PW_W-1:0] d2c_next, d2c_reg, d2c_p2_reg, d2c_a_reg, d2c_b_reg;
    assign d2w       = (D2_W'(sq_reg) << SH_L) >> SH_R;
    assign big_next  = |d2w[D2_W-1:28];
    assign d2lo_next = d2w[27:0];
    assign d2c_next  = (d2w > D2_W'(POW_CAP)) ? POW_CAP : d2w[PW_W-1:0];

    // Square of the radius term.
    logic [55:0]     sq28;
    logic [PW_W-1:0] p2_next, p2_reg, p2_a_reg, p2_b_reg;
    assign sq28    = d2lo_reg * d2lo_reg;
    assign p2_next = big_reg ? POW_CAP : {1'b0, sq28[55:16]};

    // Cube, as two partial products.
    logic [47:0] pa_next, pa_reg, pb_next, pb_reg;
    assign pa_next = p2_reg[19:0] * d2lo_p2_reg;
    assign pb_next = p2_reg[39:20] * d2lo_p2_reg;

    logic [67:0]     prod3;
    logic [PW_W-1:0] p3_next, p3_reg;
    assign prod3   = (68'(pb_reg) << 20) + 68'(pa_reg);
    assign p3_next = (big_a_reg || (|prod3[67:56])) ? POW_CAP : prod3[56:16];

    // Distortion factor.
    logic signed [F_W-1:0] f_next [3];
    logic signed [F_W-1:0] f_reg  [3];
    assign f_next[0] = $signed(coef_reg[COEF_W-1:0]) * $signed({1'b0, d2c_b_reg});
    assign f_next[1] = $signed(coef_reg[2*COEF_W-1:COEF_W]) * $signed({1'b0, p2_b_reg});
    assign f_next[2] = $signed(coef_reg[3*COEF_W-1:2*COEF_W]) * $signed({1'b0, p3_reg});

    logic signed [FACT_W-1:0] fact_next, fact_reg;
    always_comb begin
        logic signed [63:0] s;
        logic [63:0]        mag;
        logic [47:0]        rm;
        logic [PW_W-1:0]    rmc;
        s   = 64'(f_reg[0]) + 64'(f_reg[1]) + 64'(f_reg[2]);
        mag = s[63] ? 64'(-s) : 64'(s);
        rm  = 48'((mag + 64'd32768) >> 16);
        rmc = (rm > 48'(POW_CAP)) ? POW_CAP : rm[PW_W-1:0];
        fact_next = s[63] ? -$signed({1'b0, rmc}) : $signed({1'b0, rmc});
    end

    // Offsets times the factor.
    logic signed [DIS_W-1:0] px_next, px_reg, py_next, py_reg;
    assign px_next = side_reg[7].off_x * fact_reg;
    assign py_next = side_reg[7].off_y * fact_reg;

    // Output stage.
    logic [M_TDATA_W-1:0] m_tdata_next, m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_next, m_tuser_reg;
    always_comb begin
        logic [DIS_W-1:0]  mag;
        logic [47:0]       rm;
        logic signed [48:0] v;
        logic [POS_W:0]    c [2];
        logic signed [DIS_W-1:0] p [2];
        logic signed [POS_W-1:0] im [2];
        p[0]  = px_reg;
        p[1]  = py_reg;
        im[0] = side_reg[8].img_x;
        im[1] = side_reg[8].img_y;
        for (int i = 0; i < 2; i++) begin
            mag  = p[i][DIS_W-1] ? DIS_W'(-p[i]) : DIS_W'(p[i]);
            rm   = 48'((64'(mag) + 64'd32768) >> 16);
            v    = 49'(im[i]) + (p[i][DIS_W-1] ? -$signed({1'b0, rm})
                                               : $signed({1'b0, rm}));
            c[i] = clip_pos(64'(v));
        end
        if (side_reg[8].behind) begin
            m_tdata_next = '0;
            m_tuser_next = 2'b01;
        end else begin
            m_tdata_next = {c[1][POS_W-1:0], c[0][POS_W-1:0],
                            side_reg[8].img_y, side_reg[8].img_x};
            m_tuser_next = {side_reg[8].sat | c[0][POS_W] | c[1][POS_W], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg        <= d_next;
            prod_reg     <= prod_next;
            t_reg        <= t_next;
            n_reg        <= n_next;
            tz_reg       <= t_reg[2];
            behind_reg   <= behind_next;
            div_lane_reg <= div_lane_next;
            div_ctl_reg  <= div_ctl_next;
            side_reg     <= side_next;
            sq_reg       <= sq_next;
            big_reg      <= big_next;
            d2lo_reg     <= d2lo_next;
            d2c_reg      <= d2c_next;
            p2_reg       <= p2_next;
            big_p2_reg   <= big_reg;
            d2lo_p2_reg  <= d2lo_reg;
            d2c_p2_reg   <= d2c_reg;
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
            big_a_reg    <= big_p2_reg;
            p2_a_reg     <= p2_reg;
            d2c_a_reg    <= d2c_p2_reg;
            p3_reg       <= p3_next;
            p2_b_reg     <= p2_a_reg;
            d2c_b_reg    <= d2c_a_reg;
            f_reg        <= f_next;
            fact_reg     <= fact_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign m_tvalid = valid_reg[NST-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/core/php_checker.sv
module php_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [php_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [php_pkg::M_TUSER_W-1:0] m_tuser
);
    import php_pkg::*;

    // A point behind the camera carries no position and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("behind_camera result carries nonzero payload");

    // The input side stalls exactly when a result is held back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // A result that was not taken is held unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Nothing enters while stalled, so a stall cannot be followed by a new
    // result unless the old one was taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

endmodule

bind pinhole_projection_with_distortion php_checker u_php_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
